// ===== rtl/dfs_pkg.sv =====
package dfs_pkg;

    localparam int MAX_GRID    = 1024;
    localparam int ADDR_W      = $clog2(MAX_GRID);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_GRID_W  = 11;
    localparam int GW          = (CNT_W > CFG_GRID_W) ? CNT_W : CFG_GRID_W;
    localparam int FAC_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 10;
    localparam int SUM_W       = VAL_W + 4;
    localparam int PROD_W      = SUM_W + FAC_W + 1;
    localparam int FRAC_SH     = 16;
    localparam int SAT_W       = PROD_W - FRAC_SH + 2;
    localparam int OUT_BITS    = VAL_W + 2 * POS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [GW-1:0]         GRID_RESET   = GW'(64);
    localparam logic [GW-1:0]         GRID_MIN     = GW'(3);
    localparam logic [FAC_W-1:0]      FACTOR_RESET = FAC_W'(16384);
    localparam logic [PROD_W-1:0]     ROUND_HALF   = PROD_W'(1) << (FRAC_SH - 1);

    typedef enum logic [0:0] {
        CFG_GRID_SIZE   = 1'b0,
        CFG_DIFF_FACTOR = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                     vld;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     last;
        logic signed [VAL_W-1:0]  center;
        logic signed [PROD_W-1:0] acc;
    } slot_t;

    typedef struct packed {
        logic                    last;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic signed [VAL_W-1:0] value;
    } out_item_t;

endpackage

// ===== rtl/dfs_ram.sv =====
module dfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata0_reg <= mem_reg[raddr0];
            rdata1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== rtl/dfs_cell.sv =====
module dfs_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  dfs_pkg::slot_t slot_in,
    output dfs_pkg::slot_t slot_out
);

    import dfs_pkg::*;

    slot_t slot_reg;

    // advance on enable, drop the valid bit on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.vld <= 1'b0;
        end else if (adv) begin
            slot_reg.vld <= slot_in.vld;
        end
        if (adv) begin
            slot_reg.row    <= slot_in.row;
            slot_reg.col    <= slot_in.col;
            slot_reg.last   <= slot_in.last;
            slot_reg.center <= slot_in.center;
            slot_reg.acc    <= slot_in.acc;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ===== rtl/dfs_out_skid.sv =====
module dfs_out_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dfs_pkg::out_item_t item_in,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_ready,
    output dfs_pkg::out_item_t item_out
);

    import dfs_pkg::*;

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign ready     = (count_reg != 2'd2);
    assign item_out  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/diffusion_five_point_stencil_top.sv =====
// Pipeline: a word passes stage 1 and cells 1 to 3 into the output buffer before it shows on the m_ side.
// Throughput: one word per cycle while the output buffer has room, set by the dual-read row buffers and
// the single 36x17 multiplier stage; a two-entry output buffer absorbs m_tready stalls until it fills.
// Reset (aresetn low, synchronous): counters, buffer select and all valid bits clear,
// grid_size goes to 64 and diffusion_factor to 16384; row buffers are not cleared.
module diffusion_five_point_stencil_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dfs_pkg::VAL_W-1:0]           s_tdata,   // cell_value
    input  logic                                s_tuser,   // start_of_grid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dfs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // new_value, row_index, col_index, zeros
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  dfs_pkg::cfg_idx_t                   cfg_index,
    input  logic [dfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dfs_pkg::*;

    logic [GW-1:0]     grid_size_reg;
    logic [FAC_W-1:0]  factor_reg;
    logic [GW-1:0]     row_cnt_reg;
    logic [GW-1:0]     row_cnt_next;
    logic [ADDR_W-1:0] col_cnt_reg;
    logic [ADDR_W-1:0] col_cnt_next;
    logic              sel_reg;
    logic              sel_next;

    logic              adv;
    logic              accept;
    logic [GW-1:0]     g;
    logic [GW-1:0]     grid_ext;
    logic [GW-1:0]     rc;
    logic [GW-1:0]     r;
    logic [GW-1:0]     ccx;
    logic [GW-1:0]     cx;
    logic [GW-1:0]     cx_p1;
    logic [ADDR_W-1:0] c;
    logic              pad;
    logic              emit;
    logic              wrap;
    logic signed [VAL_W-1:0] cur;

    logic [VAL_W-1:0]  rd_a0;
    logic [VAL_W-1:0]  rd_a1;
    logic [VAL_W-1:0]  rd_b0;
    logic [VAL_W-1:0]  rd_b1;

    logic                    s1_vld_reg;
    logic [POS_W-1:0]        s1_row_reg;
    logic [POS_W-1:0]        s1_col_reg;
    logic                    s1_last_reg;
    logic                    s1_sel_reg;
    logic                    s1_up_en_reg;
    logic                    s1_left_en_reg;
    logic                    s1_right_en_reg;
    logic signed [VAL_W-1:0] s1_cur_reg;
    logic signed [VAL_W-1:0] s1_left_reg;

    logic signed [VAL_W-1:0] center;
    logic signed [VAL_W-1:0] up;
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] right;
    logic signed [SUM_W-1:0] nsum;

    slot_t c1_in;
    slot_t c1_out;
    slot_t c2_in;
    slot_t c2_out;
    slot_t c3_in;
    slot_t c3_out;

    logic signed [SUM_W-1:0]  mul_a;
    logic signed [FAC_W:0]    mul_b;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SAT_W-1:0]  total;
    logic                     in_range;

    out_item_t res_item;
    out_item_t out_item;
    logic      push;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_RESET;
            factor_reg    <= FACTOR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRID_SIZE:   grid_size_reg <= GW'(cfg_data[CFG_GRID_W-1:0]);
                CFG_DIFF_FACTOR: factor_reg    <= cfg_data[FAC_W-1:0];
                default:         ;
            endcase
        end
    end

    // position of the arriving word
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        grid_ext = grid_size_reg;
        if (grid_ext < GRID_MIN) begin
            g = GRID_MIN;
        end else if (grid_ext > GW'(MAX_GRID)) begin
            g = GW'(MAX_GRID);
        end else begin
            g = grid_ext;
        end
        rc    = s_tuser ? '0 : row_cnt_reg;
        r     = (rc > g) ? g : rc;
        ccx   = s_tuser ? '0 : GW'(col_cnt_reg);
        cx    = (ccx > g - GW'(1)) ? g - GW'(1) : ccx;
        cx_p1 = cx + GW'(1);
        c     = cx[ADDR_W-1:0];
        pad   = (r == g);
        emit  = (r != '0);
        wrap  = (cx_p1 >= g);
        cur   = pad ? '0 : $signed(s_tdata);

        col_cnt_next = wrap ? '0 : cx_p1[ADDR_W-1:0];
        row_cnt_next = wrap ? (pad ? '0 : r + GW'(1)) : r;
        sel_next     = wrap ? ~sel_reg : sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            sel_reg     <= 1'b0;
        end else if (accept) begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            sel_reg     <= sel_next;
        end
    end

    // row buffers: the one not selected as previous row takes the arriving word
    dfs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GRID)) u_buf_a (
        .aclk   (aclk),
        .we     (accept && !pad && sel_reg),
        .waddr  (c),
        .wdata  (cur),
        .re     (accept),
        .raddr0 (c),
        .raddr1 (cx_p1[ADDR_W-1:0]),
        .rdata0 (rd_a0),
        .rdata1 (rd_a1)
    );

    dfs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GRID)) u_buf_b (
        .aclk   (aclk),
        .we     (accept && !pad && !sel_reg),
        .waddr  (c),
        .wdata  (cur),
        .re     (accept),
        .raddr0 (c),
        .raddr1 (cx_p1[ADDR_W-1:0]),
        .rdata0 (rd_b0),
        .rdata1 (rd_b1)
    );

    // stage 1: hold position and the left neighbor, which is the last center read
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_row_reg      <= POS_W'(r - GW'(1));
            s1_col_reg      <= POS_W'(cx);
            s1_last_reg     <= pad && wrap;
            s1_sel_reg      <= sel_reg;
            s1_up_en_reg    <= (r > GW'(1));
            s1_left_en_reg  <= (cx != '0);
            s1_right_en_reg <= !wrap;
            s1_cur_reg      <= cur;
            s1_left_reg     <= sel_reg ? $signed(rd_b0) : $signed(rd_a0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= accept && emit;
        end
    end

    always_comb begin
        center = s1_sel_reg ? $signed(rd_b0) : $signed(rd_a0);
        up     = s1_up_en_reg ? (s1_sel_reg ? $signed(rd_a0) : $signed(rd_b0)) : '0;
        right  = s1_right_en_reg ? (s1_sel_reg ? $signed(rd_b1) : $signed(rd_a1)) : '0;
        left   = s1_left_en_reg ? s1_left_reg : '0;
        nsum   = SUM_W'(up) + SUM_W'(s1_cur_reg) + SUM_W'(left) + SUM_W'(right)
               - (SUM_W'(center) <<< 2);

        c1_in.vld    = s1_vld_reg;
        c1_in.row    = s1_row_reg;
        c1_in.col    = s1_col_reg;
        c1_in.last   = s1_last_reg;
        c1_in.center = center;
        c1_in.acc    = PROD_W'(nsum);
    end

    dfs_cell u_cell1 (.aclk(aclk), .aresetn(aresetn), .adv(adv), .slot_in(c1_in),
                      .slot_out(c1_out));

    always_comb begin
        mul_a     = c1_out.acc[SUM_W-1:0];
        mul_b     = $signed({1'b0, factor_reg});
        c2_in     = c1_out;
        c2_in.acc = mul_a * mul_b;
    end

    dfs_cell u_cell2 (.aclk(aclk), .aresetn(aresetn), .adv(adv), .slot_in(c2_in),
                      .slot_out(c2_out));

    always_comb begin
        rnd       = $signed(c2_out.acc) + $signed(ROUND_HALF);
        c3_in     = c2_out;
        c3_in.acc = rnd >>> FRAC_SH;
    end

    dfs_cell u_cell3 (.aclk(aclk), .aresetn(aresetn), .adv(adv), .slot_in(c3_in),
                      .slot_out(c3_out));

    // add and saturate
    always_comb begin
        total    = SAT_W'(c3_out.center) + $signed(c3_out.acc[SAT_W-1:0]);
        in_range = (&total[SAT_W-1:VAL_W-1]) || !(|total[SAT_W-1:VAL_W-1]);
        res_item.value = in_range ? total[VAL_W-1:0]
                       : (total[SAT_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                         : {1'b0, {(VAL_W-1){1'b1}}});
        res_item.row   = c3_out.row;
        res_item.col   = c3_out.col;
        res_item.last  = c3_out.last;
        push           = c3_out.vld && adv;
    end

    dfs_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .item_in   (res_item),
        .ready     (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .item_out  (out_item)
    );

    assign m_tdata = OUT_TDATA_W'({out_item.col, out_item.row, out_item.value});
    assign m_tlast = out_item.last;

    ap_start_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser |=> !s1_vld_reg)
        else $error("start of grid produced a result");

    ap_wrap_col: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && wrap |=> (col_cnt_reg == '0) && (sel_reg != $past(sel_reg)))
        else $error("row end did not wrap column and swap buffers");

    ap_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s1_vld_reg)
        else $error("valid left set after reset");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dfs_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 420;

    class stencil_scoreboard;
        int               rows [2][MAX_GRID];
        int               left_val;
        int unsigned      row_cnt;
        int unsigned      col_cnt;
        bit               sel;
        logic [10:0]      grid_reg;
        logic [15:0]      factor_reg;
        out_item_t        expected_q [$];
        int               errors;

        function new();
            left_val   = 0;
            row_cnt    = 0;
            col_cnt    = 0;
            sel        = 1'b0;
            grid_reg   = 11'd64;
            factor_reg = 16'd16384;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] d);
            if (idx == CFG_GRID_SIZE) begin
                grid_reg = d[10:0];
            end else begin
                factor_reg = d;
            end
        endfunction

        function int relax(int center, int up, int down, int lf, int rt);
            longint s;
            longint p;
            longint r;
            s = longint'(up) + longint'(down) + longint'(lf) + longint'(rt)
                - 4 * longint'(center);
            p = s * longint'(factor_reg);
            r = longint'(center) + ((p + 64'sd32768) >>> 16);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return int'(r);
        endfunction

        function void note_cell(logic [31:0] v, logic sog);
            int unsigned g;
            int unsigned r;
            int unsigned c;
            bit          pad;
            int          cur;
            int          center;
            int          up;
            int          lf;
            int          rt;
            out_item_t   item;
            g = grid_reg;
            if (g < 3) g = 3;
            if (g > MAX_GRID) g = MAX_GRID;
            if (sog) begin
                row_cnt  = 0;
                col_cnt  = 0;
                left_val = 0;
            end
            r   = (row_cnt > g) ? g : row_cnt;
            c   = (col_cnt > g - 1) ? g - 1 : col_cnt;
            pad = (r == g);
            cur = pad ? 0 : int'(v);
            if (r >= 1) begin
                center     = rows[sel][c];
                up         = (r >= 2) ? rows[!sel][c] : 0;
                lf         = (c > 0) ? left_val : 0;
                rt         = (c + 1 < g) ? rows[sel][c + 1] : 0;
                item.value = relax(center, up, cur, lf, rt);
                item.row   = POS_W'(r - 1);
                item.col   = POS_W'(c);
                item.last  = pad && (c == g - 1);
                expected_q.push_back(item);
                left_val   = center;
            end
            if (!pad) rows[!sel][c] = cur;
            if (c + 1 >= g) begin
                col_cnt  = 0;
                left_val = 0;
                sel      = !sel;
                row_cnt  = pad ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        function void report(string what, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, e, a);
            errors++;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, logic tl);
            out_item_t got;
            out_item_t exp_item;
            got.value = d[VAL_W-1:0];
            got.row   = d[VAL_W +: POS_W];
            got.col   = d[VAL_W + POS_W +: POS_W];
            got.last  = tl;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h last %b", $time, d, tl);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.value !== exp_item.value) report("new_value", exp_item.value, got.value);
            if (got.row !== exp_item.row) report("row_index", 32'(exp_item.row), 32'(got.row));
            if (got.col !== exp_item.col) report("col_index", 32'(exp_item.col), 32'(got.col));
            if (got.last !== exp_item.last) report("last", 32'(exp_item.last), 32'(got.last));
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VAL_W-1:0]       s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index = CFG_GRID_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    bit          steady      = 1'b0;
    bit          aligned     = 1'b0;
    int          cycles      = 0;
    int          random_sent = 0;
    int unsigned grid_now    = 64;

    stencil_scoreboard sb = new();

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    diffusion_five_point_stencil_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_cell(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 13);
        cycles   <= cycles + 1;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("** diffusion_five_point_stencil_top: FAILED **");
        $finish;
    end

    function automatic int unsigned effective_grid(logic [15:0] d);
        int unsigned g;
        g = d[10:0];
        if (g < 3) g = 3;
        if (g > MAX_GRID) g = MAX_GRID;
        return g;
    endfunction

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(int'($urandom_range(0, 2)) - 1);
            3, 4, 5: return $urandom;
            default: return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_factor();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd16384;
            3, 4:    return 16'($urandom_range(0, 16384));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_grid();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 2));
            1:       return 16'hF800 | 16'($urandom_range(3, 6));
            2:       return 16'($urandom_range(11, 16));
            default: return 16'($urandom_range(3, 9));
        endcase
    endfunction

    task automatic send_cell(input logic [31:0] v, input logic sog);
        while (!steady && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= sog;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        hold_off();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_register(input cfg_idx_t idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_GRID_SIZE) grid_now = effective_grid(d);
    endtask

    task automatic send_run(input int n, input bit first_sog);
        for (int i = 0; i < n; i++) begin
            send_cell(rand_cell(), first_sog && (i == 0));
        end
    endtask

    // restart mid-grid now and then, always finish on a grid boundary
    task automatic send_grid(input int unsigned g, input int pause_at);
        int   total;
        int   k;
        logic sog;
        total = g * (g + 1);
        k     = 0;
        while (k < total) begin
            sog = 1'b0;
            if (k == 0) begin
                sog = !aligned || ($urandom_range(0, 1) == 1);
            end else if ($urandom_range(0, 199) == 0) begin
                sog = 1'b1;
                k   = 0;
            end
            send_cell(rand_cell(), sog);
            if (k == pause_at) hold_off();
            k++;
            random_sent++;
        end
        aligned = 1'b1;
    endtask

    initial begin
        int          phase;
        logic [31:0] corner [9];
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting, then shrink the grid in the middle of row 2
        send_run(2 * 64 + 5, 1'b1);
        settle();
        set_register(CFG_GRID_SIZE, 16'd0);
        set_register(CFG_DIFF_FACTOR, 16'hFFFF);
        send_run(4, 1'b0);

        // checkerboard of extremes, entered by wrap-around
        for (int i = 0; i < 12; i++) begin
            send_cell((i < 9) ? corner[i] : rand_cell(), 1'b0);
        end
        aligned = 1'b1;
        send_grid(3, -1);

        // shrink while on row 4, column 4
        settle();
        set_register(CFG_GRID_SIZE, 16'd6);
        set_register(CFG_DIFF_FACTOR, 16'd16384);
        send_run(28, 1'b1);
        settle();
        set_register(CFG_GRID_SIZE, 16'd4);
        send_run(1, 1'b0);
        aligned = 1'b1;
        send_grid(4, -1);

        // grid above the largest, a few words of row 0, then shrink
        settle();
        set_register(CFG_GRID_SIZE, 16'hFFFF);
        set_register(CFG_DIFF_FACTOR, rand_factor());
        send_run(8, 1'b1);
        settle();
        set_register(CFG_GRID_SIZE, 16'd2);
        send_run(10, 1'b0);
        aligned = 1'b1;

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS || phase < 4) begin
            settle();
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                set_register(CFG_GRID_SIZE, rand_grid());
            end
            if ($urandom_range(0, 1) == 1) set_register(CFG_DIFF_FACTOR, rand_factor());
            steady = (phase == 3);
            repeat ($urandom_range(1, 2)) begin
                send_grid(grid_now, (phase == 1) ? int'(grid_now * 2) : -1);
            end
            phase++;
        end
        steady = 1'b0;

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** diffusion_five_point_stencil_top: PASSED **");
        end else begin
            $display("** diffusion_five_point_stencil_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== diffusion_five_point_stencil_top.f =====
rtl/dfs_pkg.sv
rtl/dfs_ram.sv
rtl/dfs_cell.sv
rtl/dfs_out_skid.sv
rtl/diffusion_five_point_stencil_top.sv
sim/tb.sv
